/* design/teq_pkg.sv */
// Shared constants, codes and types of the timed event queue.
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int TIME_BITS   = 32;

  localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [TIME_BITS-1:0] stamp_t;
  typedef logic [TAG_BITS-1:0]  tag_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_POPPED   = 2'd1;
  localparam status_t ST_NOTHING  = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POLL   = 1'b1;

  typedef struct packed {
    logic   mode;
    stamp_t event_time;
    tag_t   event_tag;
    stamp_t now_time;
  } in_item_t;

  typedef struct packed {
    status_t status;
    tag_t    popped_tag;
    stamp_t  popped_time;
    cnt_t    fill_count;
  } out_item_t;

  // One stored event.
  typedef struct packed {
    stamp_t stamp;
    tag_t   tag;
  } slot_t;

  // Access request from the sequencer to the slot store.
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    slot_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } ram_req_t;

endpackage

/* design/teq_if.sv */
// Valid/ready channel interfaces for the request and result streams.
interface teq_in_if;
  import teq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface teq_out_if;
  import teq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/teq_slot_store.sv */
// Event slot memory: one write port and one read port with registered read data.
module teq_slot_store (
  input  logic              clk,
  input  teq_pkg::ram_req_t req,
  output teq_pkg::slot_t    rd_data
);
  import teq_pkg::*;

  slot_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* design/teq_core_top.sv */
// Top level of the timed event queue: sequencer around a sorted ring of slots.
// A poll reads the head slot and compares it in S_POLL_CMP; a full-insert or an empty-poll goes
// straight to S_RESULT; an insert walks down from the tail with one memory read per later
// event. Requests are taken one at a time: the next request is taken once the result has
// moved into the output register, even while that result waits there.
// Reset clears the fill count, ring head and result valid flag; slot contents are kept.
module timed_event_queue_core (
  input logic       clk,
  input logic       rst,
  teq_in_if.sink    req,
  teq_out_if.source rsp
);
  import teq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_STEP,
    S_INS_CMP,
    S_POLL_CMP,
    S_RESULT
  } state_t;

  // The events live in a ring: logical slot 0 (earliest event) sits at head.
  // A pop only advances head, so it never moves data. An insert walks from the
  // tail toward the head, moving each later event up by one slot, and drops
  // the new event into the hole that is left.
  state_t    state;
  cnt_t      count;
  idx_t      head;
  idx_t      pos;       // logical index of the current hole during an insert
  stamp_t    key_time;  // event time of an insert, current time of a poll
  tag_t      key_tag;
  out_item_t res;
  out_item_t out_reg;
  logic      out_valid;

  ram_req_t  ram_req;
  slot_t     rd_data;

  logic      accept;
  logic      is_later;
  logic      load_out;

  teq_slot_store u_store (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // Physical address of a logical slot, wrapping at the queue depth.
  function automatic idx_t phys(input idx_t base, input idx_t lidx);
    logic [IDX_BITS:0] sum;
    sum = {1'b0, base} + {1'b0, lidx};
    if (sum >= (IDX_BITS + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_BITS + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_BITS-1:0];
  endfunction

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_reg;

  // The finished result moves into the output register when that register is
  // empty or its current result leaves in this same cycle.
  assign load_out = (state == S_RESULT) && (!out_valid || rsp.ready);

  // The stored event just read is strictly later than the one being inserted.
  assign is_later = key_time < rd_data.stamp;

  // Memory accesses. In the compare state a move of one event and the read of
  // the next lower slot go out in the same cycle at different addresses, so
  // the walk proceeds at one slot per cycle without any forwarding.
  always_comb begin
    ram_req         = '0;
    ram_req.wr_data = '{stamp: key_time, tag: key_tag};
    case (state)
      S_IDLE: begin
        if (accept && req.data.mode == MODE_POLL && count != '0) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = head;
        end
      end
      S_INS_STEP: begin
        if (pos == '0) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = head;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = phys(head, pos - idx_t'(1));
        end
      end
      S_INS_CMP: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = phys(head, pos);
        if (is_later) begin
          ram_req.wr_data = rd_data;
          if (pos != idx_t'(1)) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = phys(head, pos - idx_t'(2));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      // A waiting result leaves on its transfer unless a new one replaces it.
      if (load_out) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res.popped_tag  <= '0;
            res.popped_time <= '0;
            res.fill_count  <= count;
            key_tag <= req.data.event_tag;
            pos     <= count[IDX_BITS-1:0];
            if (req.data.mode == MODE_INSERT) begin
              key_time <= req.data.event_time;
              if (count == cnt_t'(QUEUE_DEPTH)) begin
                res.status <= ST_FULL;
                state      <= S_RESULT;
              end else begin
                res.status <= ST_INSERTED;
                state      <= S_INS_STEP;
              end
            end else begin
              key_time   <= req.data.now_time;
              res.status <= ST_NOTHING;
              if (count == '0) begin
                state <= S_RESULT;
              end else begin
                state <= S_POLL_CMP;
              end
            end
          end
        end
        S_INS_STEP: begin
          if (pos == '0) begin
            count          <= count + cnt_t'(1);
            res.status     <= ST_INSERTED;
            res.fill_count <= count + cnt_t'(1);
            state          <= S_RESULT;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (is_later) begin
            pos <= pos - idx_t'(1);
            // With the hole now at slot 0 the new event is written there next.
            if (pos == idx_t'(1)) begin
              state <= S_INS_STEP;
            end
          end else begin
            count          <= count + cnt_t'(1);
            res.status     <= ST_INSERTED;
            res.fill_count <= count + cnt_t'(1);
            state          <= S_RESULT;
          end
        end
        S_POLL_CMP: begin
          // An event whose time equals the current time is not yet due.
          if (rd_data.stamp < key_time) begin
            head            <= phys(head, idx_t'(1));
            count           <= count - cnt_t'(1);
            res.status      <= ST_POPPED;
            res.popped_tag  <= rd_data.tag;
            res.popped_time <= rd_data.stamp;
            res.fill_count  <= count - cnt_t'(1);
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/sv/tb_timed_event_queue_core.sv */
// Self-checking testbench of the timed event queue core with directed and random traffic.
`timescale 1ns / 100ps

module tb_timed_event_queue_core;
  import teq_pkg::*;

  // Clock, reset and the two channels around the block.
  logic clk;
  logic rst;

  teq_in_if  event_req ();
  teq_out_if event_rsp ();

  timed_event_queue_core dut (
    .clk (clk),
    .rst (rst),
    .req (event_req),
    .rsp (event_rsp)
  );

  always #1 clk = ~clk;

  // Idle behavior of both sides, in percent of cycles. The sender draws a
  // gap before each item; the receiver drops ready cycle by cycle.
  int send_idle_pct;
  int recv_stall_pct;

  // Shadow copy of the event store. Slots at and above shadow_fill are never
  // read, so they need no reset value.
  stamp_t shadow_stamp [QUEUE_DEPTH];
  tag_t   shadow_tag   [QUEUE_DEPTH];
  int     shadow_fill;

  // Results still owed by the block, oldest first.
  out_item_t pending_results [$];
  int        error_count;

  // Works out the answer of the queue to one accepted request and advances
  // the shadow store the same way the block must.
  function automatic out_item_t schedule_or_poll(in_item_t item);
    out_item_t answer;
    int        slot;
    answer = '0;
    if (item.mode == MODE_INSERT) begin
      if (shadow_fill >= QUEUE_DEPTH) begin
        // A full store drops the new event and stays as it is.
        answer.status = ST_FULL;
      end else begin
        // The new event goes in front of the first strictly later one, so
        // events with equal times leave in the order they came.
        slot = shadow_fill;
        for (int i = 0; i < shadow_fill; i++) begin
          if (item.event_time < shadow_stamp[i]) begin
            slot = i;
            break;
          end
        end
        for (int i = shadow_fill; i > slot; i--) begin
          shadow_stamp[i] = shadow_stamp[i-1];
          shadow_tag[i]   = shadow_tag[i-1];
        end
        shadow_stamp[slot] = item.event_time;
        shadow_tag[slot]   = item.event_tag;
        shadow_fill++;
        answer.status = ST_INSERTED;
      end
    end else begin
      // Only an event strictly earlier than the current time is due; an
      // empty store has nothing due at all.
      if (shadow_fill == 0 || !(shadow_stamp[0] < item.now_time)) begin
        answer.status = ST_NOTHING;
      end else begin
        answer.status      = ST_POPPED;
        answer.popped_tag  = shadow_tag[0];
        answer.popped_time = shadow_stamp[0];
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_stamp[i-1] = shadow_stamp[i];
          shadow_tag[i-1]   = shadow_tag[i];
        end
        shadow_fill--;
      end
    end
    answer.fill_count = cnt_t'(shadow_fill);
    return answer;
  endfunction

  function automatic in_item_t make_request(logic mode, stamp_t ev_time, tag_t ev_tag,
                                            stamp_t now);
    in_item_t item;
    item.mode       = mode;
    item.event_time = ev_time;
    item.event_tag  = ev_tag;
    item.now_time   = now;
    return item;
  endfunction

  // Times are mostly drawn from a narrow window so that polls find due
  // events and inserts meet equal times; the rest covers the full range.
  function automatic stamp_t random_stamp();
    stamp_t value;
    case ($urandom_range(15))
      0:       value = '0;
      1:       value = '1;
      2, 3:    value = $urandom;
      4:       value = '1 - stamp_t'($urandom_range(3));
      default: value = stamp_t'($urandom_range(40));
    endcase
    return value;
  endfunction

  // Sends one request. A random gap may come first; valid stays high after
  // the transfer so back-to-back items never toggle it within one step.
  task automatic send_request(in_item_t item);
    int        gap;
    out_item_t expected;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      event_req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    event_req.valid <= 1'b1;
    event_req.data  <= item;
    @(posedge clk);
    while (!event_req.ready) @(posedge clk);
    expected = schedule_or_poll(item);
    pending_results.insert(pending_results.size(), expected);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    event_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Boundary values and each special case of the queue, starting empty.
  task automatic test_edge_cases();
    // A poll of an empty store reports nothing due; the insert fields are
    // set to all ones to show they are ignored.
    send_request(make_request(MODE_POLL, '1, '1, '0));
    send_request(make_request(MODE_INSERT, 32'd5, 16'hAAAA, '1));
    // Equal time: this one must leave after the previous one.
    send_request(make_request(MODE_INSERT, 32'd5, 16'h5555, '0));
    send_request(make_request(MODE_INSERT, '0, '0, '1));
    send_request(make_request(MODE_INSERT, '1, '1, '0));
    // An event whose time equals now is not due yet.
    send_request(make_request(MODE_POLL, '1, '1, '0));
    send_request(make_request(MODE_POLL, '0, '0, 32'd1));
    send_request(make_request(MODE_POLL, '1, '0, 32'd6));
    send_request(make_request(MODE_POLL, '0, '1, 32'd6));
    // The latest possible time is never due.
    send_request(make_request(MODE_POLL, '0, '0, '1));
  endtask

  // Fills the store to the top, then tries two more inserts that must drop.
  task automatic test_full_store();
    while (shadow_fill < QUEUE_DEPTH)
      send_request(make_request(MODE_INSERT, random_stamp(), tag_t'($urandom), $urandom));
    send_request(make_request(MODE_INSERT, '0, '1, '1));
    send_request(make_request(MODE_INSERT, '1, '0, '0));
  endtask

  // Mixed traffic. The share of inserts changes in bursts so the store
  // swings between empty and full many times.
  task automatic test_random_traffic(int idle_pct, int stall_pct, int item_count,
                                     bit hold_midway);
    int       insert_pct;
    in_item_t item;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    insert_pct     = 50;
    for (int n = 0; n < item_count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      if (hold_midway && n == item_count / 2) wait_results_drained();
      item = make_request(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_POLL,
                          random_stamp(), tag_t'($urandom), random_stamp());
      send_request(item);
    end
  endtask

  // Every result transfer is compared with the oldest owed result.
  always @(posedge clk) begin : check_result
    out_item_t want;
    out_item_t got;
    if (!rst && event_rsp.valid && event_rsp.ready) begin
      got = event_rsp.data;
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: status %0d", got.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.popped_tag !== want.popped_tag) begin
          $error("popped_tag: expected %h, got %h", want.popped_tag, got.popped_tag);
          error_count++;
        end
        if (got.popped_time !== want.popped_time) begin
          $error("popped_time: expected %h, got %h", want.popped_time, got.popped_time);
          error_count++;
        end
        if (got.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
          error_count++;
        end
      end
    end
  end

  // The receiver decides on ready once per cycle, away from the sampling edge.
  always @(negedge clk) begin
    event_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    event_req.valid = 1'b0;
    event_req.data  = '0;
    event_rsp.ready = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    shadow_fill     = 0;
    error_count     = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_full_store();
    // Phases: no idling, a mostly idle sender with one full drain in the
    // middle, a mostly stalling receiver, and light idling on both sides.
    test_random_traffic(0, 0, 290, 1'b0);
    test_random_traffic(84, 0, 290, 1'b1);
    test_random_traffic(0, 84, 290, 1'b0);
    test_random_traffic(13, 13, 290, 1'b0);

    // Let the last results come back, then watch a while for strays.
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #1500000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
design/teq_pkg.sv
design/teq_if.sv
design/teq_slot_store.sv
design/teq_core_top.sv
tb/sv/tb_timed_event_queue_core.sv
